// ===== rtl/core/mwsk_pkg.sv =====
// Shared widths, register indexes and sign tables for the mecanum slew kinematics block.
package mwsk_pkg;

    // Payload and register widths
    localparam int CMD_W   = 15;
    localparam int OUT_W   = 24;
    localparam int GAIN_W  = 16;
    localparam int LIM_W   = 21;
    localparam int COEF_W  = 24;
    localparam int CFG_W   = 24;
    localparam int CFG_AW  = 3;

    // Internal widths: stored speed fits +/- (2^21 - 1), error and sums fit 24 bits
    localparam int SPD_W   = 22;
    localparam int ERR_W   = 24;
    localparam int MOP_W   = 25;
    localparam int PROD_W  = 2 * MOP_W;

    // Register reset values
    localparam logic [GAIN_W-1:0] GAIN_RST  = 16'd655;
    localparam logic [LIM_W-1:0]  LIM_RST   = 21'd7680;
    localparam logic [LIM_W-1:0]  MAXR_RST  = 21'd1447091;
    localparam logic [COEF_W-1:0] LINC_RST  = 24'd115478;
    localparam logic [COEF_W-1:0] ANGC_RST  = 24'd218708;

    // Configuration register indexes
    typedef enum logic [CFG_AW-1:0] {
        REG_KP_DT_GAIN   = 3'd0,
        REG_STEP_LIMIT   = 3'd1,
        REG_MAX_RPM      = 3'd2,
        REG_LINEAR_COEF  = 3'd3,
        REG_ANGULAR_COEF = 3'd4
    } t_reg_idx;

    // Result slots
    localparam logic [1:0] OUT_VX  = 2'd0;
    localparam logic [1:0] OUT_VY  = 2'd1;
    localparam logic [1:0] OUT_YAW = 2'd2;

    // Wheels 1 and 2 have their command negated
    localparam logic [3:0] WHEEL_NEG = 4'b0110;

    // Per result: bit i set means wheel i enters the sum negated
    function automatic logic [3:0] out_neg(input logic [1:0] k);
        logic [3:0] m;
        case (k)
            OUT_VX:  m = 4'b0000;
            OUT_VY:  m = 4'b0101;
            OUT_YAW: m = 4'b1001;
            default: m = 4'b0000;
        endcase
        return m;
    endfunction

endpackage

// ===== rtl/core/mecanum_wheel_slew_kinematics.sv =====
// Top level: slew-limited wheel speed tracking and mecanum forward kinematics.
//
//  channel | signals                                    | direction
//  --------+--------------------------------------------+----------
//  in      | i_in_valid, o_in_ready, i_cmd_wheel_[a..d] | to block
//  out     | o_out_valid, i_out_ready, o_vel_x/y, o_yaw | from block
//  cfg     | i_cfg_we, i_cfg_idx, i_cfg_data            | to block
//
// An item steps from transfer to result through error, multiply and update for each wheel,
// then sum, multiply and round for each result, all on one 25x25 multiplier, and a final
// load of the output register. The next item can be taken in the cycle after that load.
// Reset is synchronous and active low; stored wheel speeds clear to zero.
// A result waits in the output register; a new item is still taken meanwhile,
// and its final load waits until the output register is free.
module mecanum_wheel_slew_kinematics (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [mwsk_pkg::CMD_W-1:0]   i_cmd_wheel_a,
    input  logic signed [mwsk_pkg::CMD_W-1:0]   i_cmd_wheel_b,
    input  logic signed [mwsk_pkg::CMD_W-1:0]   i_cmd_wheel_c,
    input  logic signed [mwsk_pkg::CMD_W-1:0]   i_cmd_wheel_d,
    // output channel
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [mwsk_pkg::OUT_W-1:0]   o_vel_x,
    output logic signed [mwsk_pkg::OUT_W-1:0]   o_vel_y,
    output logic signed [mwsk_pkg::OUT_W-1:0]   o_yaw_rate,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [mwsk_pkg::CFG_AW-1:0]         i_cfg_idx,
    input  logic [mwsk_pkg::CFG_W-1:0]          i_cfg_data
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_ERR  = 8'b0000_0010,
        S_MUL  = 8'b0000_0100,
        S_UPD  = 8'b0000_1000,
        S_SUM  = 8'b0001_0000,
        S_OMUL = 8'b0010_0000,
        S_ORND = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic [1:0] r_idx, n_idx;

    // Configuration registers
    logic [mwsk_pkg::GAIN_W-1:0] r_gain;
    logic [mwsk_pkg::LIM_W-1:0]  r_lim;
    logic [mwsk_pkg::LIM_W-1:0]  r_maxr;
    logic [mwsk_pkg::COEF_W-1:0] r_linc;
    logic [mwsk_pkg::COEF_W-1:0] r_angc;

    // Datapath registers
    logic signed [mwsk_pkg::CMD_W-1:0] r_cmd [4];
    logic signed [mwsk_pkg::SPD_W-1:0] r_w   [4];
    logic signed [mwsk_pkg::ERR_W-1:0] r_err;
    logic signed [mwsk_pkg::ERR_W-1:0] r_sum;
    logic signed [mwsk_pkg::OUT_W-1:0] r_res [3];
    logic signed [mwsk_pkg::OUT_W-1:0] r_vx, r_vy, r_yaw;
    logic                              r_out_valid;

    // Multiplier hookup
    logic                                  mul_en;
    logic signed [mwsk_pkg::MOP_W-1:0]     mul_a, mul_b;
    logic signed [mwsk_pkg::PROD_W-1:0]    mul_p;

    // Combinational datapath signals
    logic signed [mwsk_pkg::CMD_W-1:0]  cmd_sel;
    logic signed [mwsk_pkg::SPD_W-1:0]  w_sel;
    logic signed [mwsk_pkg::ERR_W-1:0]  cmd_ext, cmd_q, err;
    logic signed [mwsk_pkg::ERR_W-1:0]  err_mag, lim_ext, step;
    logic                               over;
    logic signed [41:0]                 step_rnd;
    logic signed [mwsk_pkg::MOP_W-1:0]  nw, top;
    logic signed [mwsk_pkg::SPD_W-1:0]  w_new;
    logic signed [mwsk_pkg::ERR_W-1:0]  sum;
    logic [3:0]                         neg_mask;
    logic signed [mwsk_pkg::PROD_W-1:0] out_rnd;
    logic signed [25:0]                 out_q;
    logic signed [mwsk_pkg::OUT_W-1:0]  out_sat;
    logic                               in_xfer, load_out;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_xfer    = i_in_valid && o_in_ready;
    assign load_out   = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    // Error of the selected wheel against its Q.8 command
    always_comb begin
        cmd_sel = r_cmd[r_idx];
        w_sel   = r_w[r_idx];
        cmd_ext = {{(mwsk_pkg::ERR_W - mwsk_pkg::CMD_W){cmd_sel[mwsk_pkg::CMD_W-1]}}, cmd_sel};
        if (mwsk_pkg::WHEEL_NEG[r_idx]) begin
            cmd_ext = -cmd_ext;
        end
        cmd_q = {cmd_ext[mwsk_pkg::ERR_W-9:0], 8'h00};
        err   = cmd_q - {{(mwsk_pkg::ERR_W - mwsk_pkg::SPD_W){w_sel[mwsk_pkg::SPD_W-1]}}, w_sel};
    end

    // Step selection and speed clamp
    always_comb begin
        err_mag  = r_err[mwsk_pkg::ERR_W-1] ? -r_err : r_err;
        lim_ext  = {{(mwsk_pkg::ERR_W - mwsk_pkg::LIM_W){1'b0}}, r_lim};
        over     = err_mag > lim_ext;
        step_rnd = mul_p[41:0] + 42'sd32768;
        if (over) begin
            step = r_err[mwsk_pkg::ERR_W-1] ? -lim_ext : lim_ext;
        end else begin
            step = step_rnd[39:16];
        end
        nw  = {{(mwsk_pkg::MOP_W - mwsk_pkg::SPD_W){w_sel[mwsk_pkg::SPD_W-1]}}, w_sel}
            + {{(mwsk_pkg::MOP_W - mwsk_pkg::ERR_W){step[mwsk_pkg::ERR_W-1]}}, step};
        top = {{(mwsk_pkg::MOP_W - mwsk_pkg::LIM_W){1'b0}}, r_maxr};
        if (nw > top) begin
            nw = top;
        end else if (nw < -top) begin
            nw = -top;
        end
        w_new = nw[mwsk_pkg::SPD_W-1:0];
    end

    // Signed wheel sum for the current result
    always_comb begin
        neg_mask = mwsk_pkg::out_neg(r_idx);
        sum      = '0;
        for (int i = 0; i < 4; i++) begin
            if (neg_mask[i]) begin
                sum = sum - {{(mwsk_pkg::ERR_W - mwsk_pkg::SPD_W){r_w[i][mwsk_pkg::SPD_W-1]}},
                             r_w[i]};
            end else begin
                sum = sum + {{(mwsk_pkg::ERR_W - mwsk_pkg::SPD_W){r_w[i][mwsk_pkg::SPD_W-1]}},
                             r_w[i]};
            end
        end
    end

    // Q.40 to Q.16 with round half up, then saturate
    always_comb begin
        out_rnd = mul_p + 50'sd8388608;
        out_q   = out_rnd[49:24];
        if (out_q > 26'sd8388607) begin
            out_sat = 24'sh7FFFFF;
        end else if (out_q < -26'sd8388608) begin
            out_sat = 24'sh800000;
        end else begin
            out_sat = out_q[mwsk_pkg::OUT_W-1:0];
        end
    end

    // Multiplier operand select
    always_comb begin
        mul_en = (r_state == S_MUL) || (r_state == S_OMUL);
        if (r_state == S_MUL) begin
            mul_a = {r_err[mwsk_pkg::ERR_W-1], r_err};
            mul_b = {{(mwsk_pkg::MOP_W - mwsk_pkg::GAIN_W){1'b0}}, r_gain};
        end else begin
            mul_a = {r_sum[mwsk_pkg::ERR_W-1], r_sum};
            mul_b = (r_idx == mwsk_pkg::OUT_YAW) ? {1'b0, r_angc} : {1'b0, r_linc};
        end
    end

    mwsk_mul u_mul (
        .i_clk (i_clk),
        .i_en  (mul_en),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    // Sequencer
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_ERR;
                    n_idx   = 2'd0;
                end
            end
            S_ERR:  n_state = S_MUL;
            S_MUL:  n_state = S_UPD;
            S_UPD: begin
                n_idx = r_idx + 2'd1;
                n_state = (r_idx == 2'd3) ? S_SUM : S_ERR;
            end
            S_SUM:  n_state = S_OMUL;
            S_OMUL: n_state = S_ORND;
            S_ORND: begin
                if (r_idx == mwsk_pkg::OUT_YAW) begin
                    n_idx   = 2'd0;
                    n_state = S_DONE;
                end else begin
                    n_idx   = r_idx + 2'd1;
                    n_state = S_SUM;
                end
            end
            S_DONE: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= mwsk_pkg::GAIN_RST;
            r_lim  <= mwsk_pkg::LIM_RST;
            r_maxr <= mwsk_pkg::MAXR_RST;
            r_linc <= mwsk_pkg::LINC_RST;
            r_angc <= mwsk_pkg::ANGC_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mwsk_pkg::REG_KP_DT_GAIN:   r_gain <= i_cfg_data[mwsk_pkg::GAIN_W-1:0];
                mwsk_pkg::REG_STEP_LIMIT:   r_lim  <= i_cfg_data[mwsk_pkg::LIM_W-1:0];
                mwsk_pkg::REG_MAX_RPM:      r_maxr <= i_cfg_data[mwsk_pkg::LIM_W-1:0];
                mwsk_pkg::REG_LINEAR_COEF:  r_linc <= i_cfg_data[mwsk_pkg::COEF_W-1:0];
                mwsk_pkg::REG_ANGULAR_COEF: r_angc <= i_cfg_data[mwsk_pkg::COEF_W-1:0];
                default: ;
            endcase
        end
    end

    // Stored wheel speeds
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_w[i] <= '0;
            end
        end else if (r_state == S_UPD) begin
            r_w[r_idx] <= w_new;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_cmd[0] <= i_cmd_wheel_a;
            r_cmd[1] <= i_cmd_wheel_b;
            r_cmd[2] <= i_cmd_wheel_c;
            r_cmd[3] <= i_cmd_wheel_d;
        end
        if (r_state == S_ERR) begin
            r_err <= err;
        end
        if (r_state == S_SUM) begin
            r_sum <= sum;
        end
        if (r_state == S_ORND) begin
            r_res[r_idx] <= out_sat;
        end
        if (load_out) begin
            r_vx  <= r_res[0];
            r_vy  <= r_res[1];
            r_yaw <= r_res[2];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_vel_x     = r_vx;
    assign o_vel_y     = r_vy;
    assign o_yaw_rate  = r_yaw;

    // Checks
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state == S_ERR) && (r_idx == 2'd0))
        else $error("item transfer did not start wheel 0");

    a_wheels_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) && (r_idx == 2'd3) |=> (r_state == S_SUM) && (r_idx == 2'd0))
        else $error("kinematics did not follow the last wheel update");

    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_DONE))
        else $error("result shown without a finished item");

endmodule

// ===== rtl/core/mwsk_mul.sv =====
// Shared registered signed multiplier used for both the slew gain and the kinematics.
module mwsk_mul (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic signed [mwsk_pkg::MOP_W-1:0]    i_a,
    input  logic signed [mwsk_pkg::MOP_W-1:0]    i_b,
    output logic signed [mwsk_pkg::PROD_W-1:0]   o_p
);

    logic signed [mwsk_pkg::PROD_W-1:0] r_p;
    logic signed [mwsk_pkg::PROD_W-1:0] n_p;

    // One product per enabled cycle
    always_comb begin
        n_p = i_a * i_b;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= n_p;
        end
    end

    assign o_p = r_p;

endmodule

// ===== tb/sv/tb_mecanum_wheel_slew_kinematics.sv =====
// Self-checking testbench for the mecanum wheel slew limiter and forward kinematics block.
`timescale 1ns / 100ps

module tb_mecanum_wheel_slew_kinematics;
    import mwsk_pkg::*;

    localparam int CLK_PERIOD     = 4;
    localparam int RESET_CYCLES   = 7;
    localparam int NUM_DIR        = 20;
    localparam int NUM_PHASES     = 8;
    localparam int PHASE_ITEMS    = 80;
    localparam int WATCHDOG_LIMIT = 500;
    localparam int END_HOLD       = 40;

    // Register settings used by the directed table
    typedef enum logic [1:0] {
        SET_RESET,
        SET_ZERO_CAP,
        SET_LIMIT_TIE,
        SET_FULL_SCALE
    } plan_cfg_e;

    typedef struct packed {
        logic signed [OUT_W-1:0] vx;
        logic signed [OUT_W-1:0] vy;
        logic signed [OUT_W-1:0] yaw;
    } kin_result_t;

    typedef struct packed {
        plan_cfg_e setting;
        int        a;
        int        b;
        int        c;
        int        d;
        bit        typed;
        int        ex;
        int        ey;
        int        eyaw;
    } dir_row_t;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_in_valid;
    logic                      o_in_ready;
    logic signed [CMD_W-1:0]   i_cmd_wheel_a;
    logic signed [CMD_W-1:0]   i_cmd_wheel_b;
    logic signed [CMD_W-1:0]   i_cmd_wheel_c;
    logic signed [CMD_W-1:0]   i_cmd_wheel_d;
    logic                      o_out_valid;
    logic                      i_out_ready;
    logic signed [OUT_W-1:0]   o_vel_x;
    logic signed [OUT_W-1:0]   o_vel_y;
    logic signed [OUT_W-1:0]   o_yaw_rate;
    logic                      i_cfg_we;
    logic [CFG_AW-1:0]         i_cfg_idx;
    logic [CFG_W-1:0]          i_cfg_data;

    // Predictor mirror of registers and stored wheel speeds (rpm Q.8)
    logic [GAIN_W-1:0]         kp_gain;
    logic [LIM_W-1:0]          slew_lim;
    logic [LIM_W-1:0]          rpm_cap;
    logic [COEF_W-1:0]         lin_k;
    logic [COEF_W-1:0]         ang_k;
    longint                    wheel_q8 [4];

    kin_result_t               pending_kin [$];
    dir_row_t                  directed_plan [NUM_DIR];
    int unsigned               fail_count = 0;
    int unsigned               quiet_cycles = 0;
    bit                        idle_on = 1'b1;

    mecanum_wheel_slew_kinematics u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_cmd_wheel_a (i_cmd_wheel_a),
        .i_cmd_wheel_b (i_cmd_wheel_b),
        .i_cmd_wheel_c (i_cmd_wheel_c),
        .i_cmd_wheel_d (i_cmd_wheel_d),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_vel_x       (o_vel_x),
        .o_vel_y       (o_vel_y),
        .o_yaw_rate    (o_yaw_rate),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Q.40 product to Q.16, round half up, saturate
    function automatic logic signed [OUT_W-1:0] scale_q16(input longint coef, input longint sum);
        longint r;
        r = (coef * sum + (longint'(1) <<< 23)) >>> 24;
        if (r > longint'(8388607))
            r = 8388607;
        if (r < -longint'(8388608))
            r = -8388608;
        return r[OUT_W-1:0];
    endfunction

    // One control tick: slew each wheel toward its command, clamp, then solve body motion
    function automatic kin_result_t track_and_solve(input logic signed [CMD_W-1:0] a,
                                                    input logic signed [CMD_W-1:0] b,
                                                    input logic signed [CMD_W-1:0] c,
                                                    input logic signed [CMD_W-1:0] d);
        logic signed [CMD_W-1:0] cmd [4];
        longint                  w [4];
        longint                  tgt;
        longint                  err;
        longint                  mag;
        longint                  stp;
        longint                  nw;
        longint                  lim;
        longint                  top;
        kin_result_t             res;
        cmd[0] = a;
        cmd[1] = b;
        cmd[2] = c;
        cmd[3] = d;
        lim = longint'(slew_lim);
        top = longint'(rpm_cap);
        for (int i = 0; i < 4; i++) begin
            tgt = longint'(cmd[i]);
            if (WHEEL_NEG[i])
                tgt = -tgt;
            tgt = tgt * 256;
            err = tgt - wheel_q8[i];
            mag = (err < 0) ? -err : err;
            // strict compare: an error equal to the limit takes the proportional step
            if (mag > lim)
                stp = (err < 0) ? -lim : lim;
            else
                stp = (err * longint'(kp_gain) + 32768) >>> 16;
            nw = wheel_q8[i] + stp;
            if (nw > top)
                nw = top;
            if (nw < -top)
                nw = -top;
            wheel_q8[i] = nw;
            w[i] = nw;
        end
        res.vx  = scale_q16(longint'(lin_k),  w[0] + w[1] + w[2] + w[3]);
        res.vy  = scale_q16(longint'(lin_k), -w[0] + w[1] - w[2] + w[3]);
        res.yaw = scale_q16(longint'(ang_k), -w[0] + w[1] + w[2] - w[3]);
        return res;
    endfunction

    // Register write; enable is lowered by the caller after the last write
    task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            REG_KP_DT_GAIN:   kp_gain  = val[GAIN_W-1:0];
            REG_STEP_LIMIT:   slew_lim = val[LIM_W-1:0];
            REG_MAX_RPM:      rpm_cap  = val[LIM_W-1:0];
            REG_LINEAR_COEF:  lin_k    = val[COEF_W-1:0];
            REG_ANGULAR_COEF: ang_k    = val[COEF_W-1:0];
            default: ;
        endcase
    endtask

    // Fixed settings of the directed part
    task automatic apply_setting(input plan_cfg_e s);
        case (s)
            SET_ZERO_CAP: begin
                // upper data bits beyond each register width must be dropped
                write_reg(REG_KP_DT_GAIN, 24'hFF028F);
                write_reg(REG_STEP_LIMIT, 24'hE01E00);
                write_reg(REG_MAX_RPM,    24'hE00000);
            end
            SET_LIMIT_TIE: begin
                write_reg(REG_KP_DT_GAIN, '0);
                write_reg(REG_STEP_LIMIT, 24'd256);
                write_reg(REG_MAX_RPM,    CFG_W'(MAXR_RST));
                for (int u = int'(REG_ANGULAR_COEF) + 1; u < (1 << CFG_AW); u++)
                    write_reg(CFG_AW'(u), '1);
            end
            SET_FULL_SCALE: begin
                write_reg(REG_KP_DT_GAIN,   '1);
                write_reg(REG_STEP_LIMIT,   '1);
                write_reg(REG_MAX_RPM,      '1);
                write_reg(REG_LINEAR_COEF,  '1);
                write_reg(REG_ANGULAR_COEF, '1);
            end
            default: ;
        endcase
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [CFG_W-1:0] pick_reg_val(input int typ);
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2, 3:    return CFG_W'($urandom);
            default: return CFG_W'(typ + int'($urandom_range(0, typ)) - typ / 2);
        endcase
    endfunction

    // Random or reset-value register setting for one phase, plus a stray write to an unused index
    task automatic shuffle_registers(input bit typical);
        if (typical) begin
            write_reg(REG_KP_DT_GAIN,   CFG_W'(GAIN_RST));
            write_reg(REG_STEP_LIMIT,   CFG_W'(LIM_RST));
            write_reg(REG_MAX_RPM,      CFG_W'(MAXR_RST));
            write_reg(REG_LINEAR_COEF,  CFG_W'(LINC_RST));
            write_reg(REG_ANGULAR_COEF, CFG_W'(ANGC_RST));
        end else begin
            write_reg(REG_KP_DT_GAIN,   pick_reg_val(int'(GAIN_RST) * 20));
            write_reg(REG_STEP_LIMIT,   pick_reg_val(int'(LIM_RST) * 4));
            write_reg(REG_MAX_RPM,      pick_reg_val(int'(MAXR_RST)));
            write_reg(REG_LINEAR_COEF,  pick_reg_val(int'(LINC_RST) * 8));
            write_reg(REG_ANGULAR_COEF, pick_reg_val(int'(ANGC_RST) * 8));
        end
        write_reg(CFG_AW'($urandom_range(int'(REG_ANGULAR_COEF) + 1, (1 << CFG_AW) - 1)),
                  CFG_W'($urandom));
        i_cfg_we <= 1'b0;
    endtask

    // Present one tick and wait for its transfer; valid stays up for a following item
    task automatic send_cmd(input logic signed [CMD_W-1:0] a, input logic signed [CMD_W-1:0] b,
                            input logic signed [CMD_W-1:0] c, input logic signed [CMD_W-1:0] d,
                            input bit use_table, input kin_result_t table_want);
        kin_result_t pred;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_cmd_wheel_a <= a;
        i_cmd_wheel_b <= b;
        i_cmd_wheel_c <= c;
        i_cmd_wheel_d <= d;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        pred = track_and_solve(a, b, c, d);
        pending_kin.push_back(use_table ? table_want : pred);
    endtask

    // Stop sending and wait for every outstanding result
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_kin.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic signed [CMD_W-1:0] pick_cmd();
        case ($urandom_range(0, 5))
            0:       return {1'b0, {(CMD_W - 1){1'b1}}};
            1:       return {1'b1, {(CMD_W - 1){1'b0}}};
            2:       return CMD_W'(int'($urandom_range(0, 64)) - 32);
            default: return CMD_W'($urandom);
        endcase
    endfunction

    // Mostly held commands so the wheels settle, with single noisy ticks mixed in
    task automatic run_random_phase(input int unsigned n_items);
        logic signed [CMD_W-1:0] hold [4];
        int unsigned             run_left;
        run_left = 0;
        for (int k = 0; k < n_items; k++) begin
            if (run_left == 0) begin
                run_left = $urandom_range(1, 20);
                for (int j = 0; j < 4; j++)
                    hold[j] = pick_cmd();
            end
            run_left--;
            if ($urandom_range(0, 3) == 0)
                send_cmd(CMD_W'($urandom), CMD_W'($urandom), CMD_W'($urandom),
                         CMD_W'($urandom), 1'b0, '0);
            else
                send_cmd(hold[0], hold[1], hold[2], hold[3], 1'b0, '0);
        end
    endtask

    // Output side: random stall bursts while idling is enabled
    initial begin
        i_out_ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (idle_on && $urandom_range(0, 4) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    // Result checker and watchdog
    always @(posedge i_clk) begin : result_check
        kin_result_t want;
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
                $display("== FAIL ==");
                $finish;
            end
            if (o_out_valid && i_out_ready) begin
                if (pending_kin.size() == 0) begin
                    $display("%0t: unexpected result expected none, got %0d %0d %0d",
                             $time, o_vel_x, o_vel_y, o_yaw_rate);
                    fail_count++;
                end else begin
                    want = pending_kin.pop_front();
                    if (o_vel_x !== want.vx) begin
                        $display("%0t: vel_x expected %0d, got %0d",
                                 $time, $signed(want.vx), o_vel_x);
                        fail_count++;
                    end
                    if (o_vel_y !== want.vy) begin
                        $display("%0t: vel_y expected %0d, got %0d",
                                 $time, $signed(want.vy), o_vel_y);
                        fail_count++;
                    end
                    if (o_yaw_rate !== want.yaw) begin
                        $display("%0t: yaw_rate expected %0d, got %0d",
                                 $time, $signed(want.yaw), o_yaw_rate);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Main sequence: reset, directed table, random phases, drain
    initial begin
        plan_cfg_e cur_setting;
        dir_row_t  row;

        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_cmd_wheel_a <= '0;
        i_cmd_wheel_b <= '0;
        i_cmd_wheel_c <= '0;
        i_cmd_wheel_d <= '0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= '0;
        i_cfg_data    <= '0;

        kp_gain  = GAIN_RST;
        slew_lim = LIM_RST;
        rpm_cap  = MAXR_RST;
        lin_k    = LINC_RST;
        ang_k    = ANGC_RST;
        for (int i = 0; i < 4; i++)
            wheel_q8[i] = 0;

        // setting, wheel a..d commands, typed flag, typed vel_x / vel_y / yaw_rate
        directed_plan = '{
            // zero command straight after reset
            '{SET_RESET,           0,      0,      0,      0, 1'b1, 0, 0, 0},
            '{SET_RESET,       16383, -16384, -16384,  16383, 1'b0, 0, 0, 0},
            '{SET_RESET,       16383, -16384, -16384,  16383, 1'b0, 0, 0, 0},
            '{SET_RESET,      -16384,  16383,  16383, -16384, 1'b0, 0, 0, 0},
            '{SET_RESET,       16383,  16383, -16384, -16384, 1'b0, 0, 0, 0},
            '{SET_RESET,           1,     -1,      1,     -1, 1'b0, 0, 0, 0},
            // zero speed cap holds every wheel at rest
            '{SET_ZERO_CAP,    16383, -16384, -16384,  16383, 1'b1, 0, 0, 0},
            '{SET_ZERO_CAP,   -16384,  16383,  16383, -16384, 1'b1, 0, 0, 0},
            '{SET_ZERO_CAP,     5000,  -7000,    300, -16384, 1'b1, 0, 0, 0},
            // error exactly at the limit with zero gain: no move; larger errors step by the limit
            '{SET_LIMIT_TIE,       1,     -1,     -1,      1, 1'b1, 0, 0, 0},
            '{SET_LIMIT_TIE,      -1,      1,      1,     -1, 1'b1, 0, 0, 0},
            '{SET_LIMIT_TIE,       2,     -2,     -2,      2, 1'b0, 0, 0, 0},
            '{SET_LIMIT_TIE,       0,      0,      0,      0, 1'b0, 0, 0, 0},
            '{SET_LIMIT_TIE,   16383, -16384,   9999,  -4321, 1'b0, 0, 0, 0},
            // full-scale gain, limit, cap and coefficients
            '{SET_FULL_SCALE,  16383, -16384, -16384,  16383, 1'b0, 0, 0, 0},
            '{SET_FULL_SCALE,  16383, -16384, -16384,  16383, 1'b0, 0, 0, 0},
            '{SET_FULL_SCALE, -16384,  16383,  16383, -16384, 1'b0, 0, 0, 0},
            '{SET_FULL_SCALE, -16384,  16383,  16383, -16384, 1'b0, 0, 0, 0},
            '{SET_FULL_SCALE,  16383,  16383, -16384, -16384, 1'b0, 0, 0, 0},
            '{SET_FULL_SCALE, -16384, -16384,  16383,  16383, 1'b0, 0, 0, 0}
        };

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part
        cur_setting = SET_RESET;
        for (int r = 0; r < NUM_DIR; r++) begin
            row = directed_plan[r];
            if (row.setting != cur_setting) begin
                settle();
                apply_setting(row.setting);
                cur_setting = row.setting;
            end
            send_cmd(CMD_W'(row.a), CMD_W'(row.b), CMD_W'(row.c), CMD_W'(row.d), row.typed,
                     '{vx: OUT_W'(row.ex), vy: OUT_W'(row.ey), yaw: OUT_W'(row.eyaw)});
        end

        // Random phases; the last one runs at typical settings with no idling
        for (int p = 0; p < NUM_PHASES; p++) begin
            settle();
            if (p == NUM_PHASES - 1)
                idle_on = 1'b0;
            shuffle_registers(p == NUM_PHASES - 1);
            run_random_phase(PHASE_ITEMS);
        end

        settle();
        repeat (END_HOLD) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
